// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module of the block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define CRAX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CRAX_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/crax_pkg.sv -----
// Shared types, constants and ARX helper functions of the CRAX-S block cipher.
// No dependencies.
package crax_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned StepCount  = 10;
  localparam int unsigned RoundCount = 4;   // Alzette rounds per step
  localparam int unsigned ConstCount = 5;
  localparam int unsigned CfgIdxW    = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKey0 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 2'd3;

  // Operation codes
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  localparam logic [WordW-1:0] AlzConst [ConstCount] = '{
    32'hB7E1_5162, 32'hBF71_5880, 32'h38B4_DA56, 32'h324E_7738, 32'hBB11_85EB
  };

  // Rotation of y into the add, and of x into the y update, per forward round
  localparam int unsigned RotAdd [RoundCount] = '{31, 17, 0, 24};
  localparam int unsigned RotXor [RoundCount] = '{24, 17, 31, 16};

  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic [WordW-1:0] k3;
  } key_t;

  typedef struct packed {
    logic             op;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } blk_t;

  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } word_pair_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v,
                                            input int unsigned amt);
    logic [WordW-1:0] r;
    if (amt == 0) begin
      r = v;
    end else begin
      r = (v >> amt) | (v << (WordW - amt));
    end
    return r;
  endfunction

  // Key material of one step: even steps use words 0/1, odd steps words 2/3
  function automatic word_pair_t step_key(input key_t k, input int unsigned s);
    word_pair_t p;
    if ((s % 2) == 0) begin
      p.x = k.k0 ^ WordW'(s);
      p.y = k.k1;
    end else begin
      p.x = k.k2 ^ WordW'(s);
      p.y = k.k3;
    end
    return p;
  endfunction

endpackage

// ----- hw/rtl/crax_cfg.sv -----
// Key register file of the CRAX-S block cipher, written over the config channel.
// Depends on crax_pkg.
module crax_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [crax_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [crax_pkg::WordW-1:0]   cfg_data_i,
  output crax_pkg::key_t               key_o
);

  crax_pkg::key_t key_q, key_d;

  // Always take a config transaction
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crax_pkg::RegKey0: key_d.k0 = cfg_data_i;
        crax_pkg::RegKey1: key_d.k1 = cfg_data_i;
        crax_pkg::RegKey2: key_d.k2 = cfg_data_i;
        crax_pkg::RegKey3: key_d.k3 = cfg_data_i;
        default:           key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ----- hw/rtl/crax_round.sv -----
// One pipeline stage: a single Alzette round, forward or inverse per item,
// with the step key mixed in where the schedule needs it. Depends on crax_pkg.
module crax_round #(
  parameter int unsigned EncStep = 0,
  parameter int unsigned DecStep = 0,
  parameter int unsigned Round   = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  crax_pkg::blk_t blk_i,
  input  crax_pkg::key_t key_i,
  output logic           valid_o,
  input  logic           ready_i,
  output crax_pkg::blk_t blk_o
);

  localparam int unsigned LastRound = crax_pkg::RoundCount - 1;
  localparam int unsigned InvRound  = LastRound - Round;
  localparam logic [crax_pkg::WordW-1:0] EncConst =
    crax_pkg::AlzConst[EncStep % crax_pkg::ConstCount];
  localparam logic [crax_pkg::WordW-1:0] DecConst =
    crax_pkg::AlzConst[DecStep % crax_pkg::ConstCount];
  localparam int unsigned EncRotA = crax_pkg::RotAdd[Round];
  localparam int unsigned EncRotB = crax_pkg::RotXor[Round];
  localparam int unsigned DecRotA = crax_pkg::RotAdd[InvRound];
  localparam int unsigned DecRotB = crax_pkg::RotXor[InvRound];

  logic                        valid_q;
  crax_pkg::blk_t              blk_q, blk_d;
  crax_pkg::word_pair_t        enc_key, dec_key;
  logic [crax_pkg::WordW-1:0]  ex, ey, dx, dy;

  assign enc_key = crax_pkg::step_key(key_i, EncStep);
  assign dec_key = crax_pkg::step_key(key_i, DecStep);

  // Forward round; key mixing precedes the first round of a step
  always_comb begin
    ex = blk_i.x;
    ey = blk_i.y;
    if (Round == 0) begin
      ex = ex ^ enc_key.x;
      ey = ey ^ enc_key.y;
    end
    ex = ex + crax_pkg::rotr(ey, EncRotA);
    ey = ey ^ crax_pkg::rotr(ex, EncRotB);
    ex = ex ^ EncConst;
  end

  // Inverse round; key removal follows the last inverse round of a step
  always_comb begin
    dx = blk_i.x ^ DecConst;
    dy = blk_i.y ^ crax_pkg::rotr(dx, DecRotB);
    dx = dx - crax_pkg::rotr(dy, DecRotA);
    if (Round == LastRound) begin
      dx = dx ^ dec_key.x;
      dy = dy ^ dec_key.y;
    end
  end

  // Select by operation
  always_comb begin
    blk_d.op = blk_i.op;
    if (blk_i.op == crax_pkg::OpDecrypt) begin
      blk_d.x = dx;
      blk_d.y = dy;
    end else begin
      blk_d.x = ex;
      blk_d.y = ey;
    end
  end

  // Advance when the stage is empty or its content moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

// ----- hw/rtl/crax_s10_block_cipher.sv -----
// Top level of the CRAX-S block cipher: key registers, round pipeline and
// whitening output register. Depends on crax_pkg, crax_cfg and crax_round.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | op_i, left_in_i, right_in_i
//  out     | out       | out_valid_o/out_ready_i | left_out_o, right_out_o
//
// One block enters per cycle while the pipeline is not stalled. There is one register
// stage per Alzette round plus the output register, which applies the final
// whitening of encryption. Reset clears all valid bits and the key words.
// Each stage holds its block while the next one is full; an empty stage
// takes new data even when the output is stalled. cfg_ready_o is always high.
module crax_s10_block_cipher #(
  parameter int unsigned STEP_COUNT = crax_pkg::StepCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [crax_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [crax_pkg::WordW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [crax_pkg::WordW-1:0]   left_in_i,
  input  logic [crax_pkg::WordW-1:0]   right_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [crax_pkg::WordW-1:0]   left_out_o,
  output logic [crax_pkg::WordW-1:0]   right_out_o
);

  localparam int unsigned NumStages = crax_pkg::RoundCount * STEP_COUNT;

  crax_pkg::key_t  key;
  logic            stg_valid [NumStages+1];
  logic            stg_ready [NumStages+1];
  crax_pkg::blk_t  stg_blk   [NumStages+1];

  logic            out_valid_q;
  logic            out_ready;
  crax_pkg::blk_t  out_blk_q, out_blk_d;

  crax_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key)
  );

  // Apply the initial whitening for decryption at the pipeline entry
  always_comb begin
    stg_blk[0].op = op_i;
    stg_blk[0].x  = left_in_i;
    stg_blk[0].y  = right_in_i;
    if (op_i == crax_pkg::OpDecrypt) begin
      stg_blk[0].x = left_in_i ^ key.k0;
      stg_blk[0].y = right_in_i ^ key.k1;
    end
  end

  assign stg_valid[0] = in_valid_i;
  assign in_ready_o   = stg_ready[0];

  // Round pipeline
  for (genvar j = 0; j < NumStages; j++) begin : g_stage
    crax_round #(
      .EncStep (j / crax_pkg::RoundCount),
      .DecStep (STEP_COUNT - 1 - j / crax_pkg::RoundCount),
      .Round   (j % crax_pkg::RoundCount)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[j]),
      .ready_o (stg_ready[j]),
      .blk_i   (stg_blk[j]),
      .key_i   (key),
      .valid_o (stg_valid[j+1]),
      .ready_i (stg_ready[j+1]),
      .blk_o   (stg_blk[j+1])
    );
  end

  // Apply the final whitening for encryption into the output register
  always_comb begin
    out_blk_d = stg_blk[NumStages];
    if (stg_blk[NumStages].op == crax_pkg::OpEncrypt) begin
      out_blk_d.x = stg_blk[NumStages].x ^ key.k0;
      out_blk_d.y = stg_blk[NumStages].y ^ key.k1;
    end
  end

  assign out_ready            = !out_valid_q || out_ready_i;
  assign stg_ready[NumStages] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= stg_valid[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && stg_valid[NumStages]) begin
      out_blk_q <= out_blk_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_blk_q.x;
  assign right_out_o = out_blk_q.y;

endmodule

// ----- hw/rtl/crax_checker.sv -----
// Port-level checks of the CRAX-S block cipher, bound to its top level.
// Depends on assert_macros.svh and crax_pkg.
`include "assert_macros.svh"

module crax_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [crax_pkg::WordW-1:0]   left_out_o,
  input logic [crax_pkg::WordW-1:0]   right_out_o
);

  // Hold a stalled result
  `CRAX_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out valid dropped")

  // Keep the stalled payload unchanged
  `CRAX_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(left_out_o) && $stable(right_out_o), "out payload changed")

  // Input back-pressure only comes from a full pipeline behind a stalled output
  `CRAX_ASSERT_NR(a_stall_src, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output stall")

  // A result transaction frees the whole chain
  `CRAX_ASSERT_NR(a_drain_ready, out_valid_o && out_ready_i |-> in_ready_o, "input not ready while output drains")

endmodule

bind crax_s10_block_cipher crax_checker u_crax_checker (.*);
